// File: hw/rtl/jtq_pkg.sv
// Package: types and constants for the job table queue engine.
`default_nettype none
package jtq_pkg;
    localparam int unsigned DEPTH_DEF = 16;

    localparam logic [2:0] OP_ENQ = 3'd0;
    localparam logic [2:0] OP_DEQ = 3'd1;
    localparam logic [2:0] OP_MOD = 3'd2;
    localparam logic [2:0] OP_CHG = 3'd3;
    localparam logic [2:0] OP_PRO = 3'd4;
    localparam logic [2:0] OP_SRT = 3'd5;

    localparam logic [2:0] ST_OK   = 3'd0;
    localparam logic [2:0] ST_DUP  = 3'd1;
    localparam logic [2:0] ST_NONE = 3'd2;
    localparam logic [2:0] ST_EMPT = 3'd3;
    localparam logic [2:0] ST_FULL = 3'd4;

    localparam logic [2:0] FS_PRI = 3'd1;
    localparam logic [2:0] FS_KND = 3'd2;
    localparam logic [2:0] FS_CPU = 3'd3;
    localparam logic [2:0] FS_MEM = 3'd4;

    localparam logic [2:0] SK_ID  = 3'd1;
    localparam logic [2:0] SK_PRI = 3'd2;
    localparam logic [2:0] SK_KND = 3'd3;
    localparam logic [2:0] SK_CPU = 3'd4;
    localparam logic [2:0] SK_MEM = 3'd5;

    typedef struct packed {
        logic [2:0]  operation;
        logic [15:0] job_id;
        logic [3:0]  priority_req;
        logic [3:0]  job_kind;
        logic [31:0] cpu_time;
        logic [31:0] memory_used;
        logic [2:0]  field_select;
        logic [31:0] field_value;
        logic [7:0]  positions;
        logic [2:0]  sort_key;
    } t_in;

    typedef struct packed {
        logic [2:0]  status;
        logic [4:0]  position;
        logic [4:0]  occupancy;
        logic [15:0] out_job_id;
        logic [3:0]  out_priority;
        logic [3:0]  out_job_kind;
        logic [31:0] out_cpu_time;
        logic [31:0] out_memory_used;
    } t_out;

    typedef struct packed {
        logic [15:0] id;
        logic [3:0]  pri;
        logic [3:0]  kind;
        logic [31:0] cpu;
        logic [31:0] mem;
    } t_rec;
endpackage
`default_nettype wire

// File: hw/rtl/job_table_queue_engine_top.sv
// Top level: job queue engine with a sequenced walk over a slot memory.
`default_nettype none
// Jobs sit in a slot memory (one record per slot) accessed by one read and one
// write a cycle, driven by a small sequencer with one shared 32-bit key compare.
// Every transaction yields exactly one result; the block takes no new
// transaction until that result has been accepted. Count, an unused
// operation and a reorder with an unused key or fewer than two jobs go
// straight to the result; an id lookup walks the slots from the head, a read
// and a check per slot, and a modify or change hit is then written back;
// dequeue shifts every job one place toward the head; promote shifts each
// job it passes one place toward the tail; reorder is a selection sort that
// swaps only when the minimum of a pass is not already in place.
// No clearing pass is needed after reset.
module job_table_queue_engine_top
    import jtq_pkg::*;
#(
    parameter int unsigned DEPTH = DEPTH_DEF
) (
    input  wire          i_clk,
    input  wire          i_rst_n,
    input  wire          i_valid,
    output logic         o_ready,
    input  jtq_pkg::t_in i_data,
    output logic         o_valid,
    input  wire          i_ready,
    output jtq_pkg::t_out o_data
);
    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    typedef enum logic [3:0] {
        S_IDLE, S_FRD, S_FCHK, S_ACT, S_SHRD, S_SHWR, S_SRD, S_SCMP,
        S_SWA, S_SWB, S_SWC, S_DONE
    } t_state;

    t_rec mem_q [DEPTH];
    t_rec r_rd;
    logic [AW-1:0] rd_addr, wr_addr;
    logic          wr_en;
    t_rec          wr_data;

    t_state r_state;
    t_in    r_req;
    logic [CW-1:0] r_cnt;
    logic [AW-1:0] r_i, r_j, r_m, r_tgt;
    logic [31:0]   r_mkey;
    t_rec          r_hold, r_tmp;
    t_out          r_out;
    logic          r_ov;
    logic          r_hit;

    always_ff @(posedge i_clk) begin
        if (wr_en) mem_q[wr_addr] <= wr_data;
        r_rd <= mem_q[rd_addr];
    end

    function automatic logic [31:0] key_f(t_rec r, logic [2:0] k);
        unique case (k)
            SK_ID:   key_f = {16'd0, r.id};
            SK_PRI:  key_f = {28'd0, r.pri};
            SK_KND:  key_f = {28'd0, r.kind};
            SK_CPU:  key_f = r.cpu;
            default: key_f = r.mem;
        endcase
    endfunction

    function automatic logic [3:0] sat4(logic [31:0] v);
        sat4 = (v > 32'd15) ? 4'hF : v[3:0];
    endfunction

    function automatic logic [4:0] p5(logic [AW-1:0] a);
        logic [AW+4:0] w;
        w = {5'd0, a};
        p5 = w[4:0];
    endfunction

    logic [CW+4:0] cnt_w;
    logic [CW-1:0] i_ext, j_ext;
    t_rec          upd;
    logic [31:0]   scan_key;
    logic          key_lt;
    logic [AW+7:0] pos_w, tgt_w, pro_diff;
    logic [AW-1:0] pro_dst;
    logic          pro_shift;
    logic          enq_ok;
    assign cnt_w = {5'd0, r_cnt};
    assign i_ext = CW'(r_i);
    assign j_ext = CW'(r_j);

    // shared compare: key of the slot just read against the running minimum
    assign scan_key = key_f(r_rd, r_req.sort_key);
    assign key_lt = (scan_key < r_mkey);

    // promote target, clamped at the head
    assign pos_w = {{AW{1'b0}}, r_req.positions};
    assign tgt_w = {8'd0, r_tgt};
    assign pro_diff = tgt_w - pos_w;
    assign pro_dst = (pos_w >= tgt_w) ? '0 : pro_diff[AW-1:0];
    assign pro_shift = r_hit && (r_req.operation == OP_PRO) && (pro_dst != r_tgt);

    assign enq_ok = (r_req.operation == OP_ENQ) && (r_out.status == ST_OK);

    // updated record for modify/change
    always_comb begin
        upd = r_tmp;
        if (r_req.operation == OP_MOD) begin
            upd.pri = r_req.priority_req;
            upd.kind = r_req.job_kind;
            upd.cpu = r_req.cpu_time;
            upd.mem = r_req.memory_used;
        end else begin
            unique case (r_req.field_select)
                FS_PRI:  upd.pri = sat4(r_req.field_value);
                FS_KND:  upd.kind = sat4(r_req.field_value);
                FS_CPU:  upd.cpu = r_req.field_value;
                FS_MEM:  upd.mem = r_req.field_value;
                default: ;
            endcase
        end
    end

    always_comb begin
        rd_addr = r_i;
        wr_en = 1'b0;
        wr_addr = r_i;
        wr_data = r_hold;
        unique case (r_state)
            S_ACT: begin
                wr_en = r_hit && (r_req.operation == OP_MOD || r_req.operation == OP_CHG);
                wr_addr = r_tgt;
                wr_data = upd;
            end
            S_SHWR: begin
                wr_en = 1'b1;
                wr_addr = r_j;
                wr_data = r_rd;
            end
            S_SRD: rd_addr = r_i + AW'(1);
            S_SCMP: rd_addr = r_j + AW'(1);
            S_SWB: begin
                wr_en = 1'b1;
                wr_addr = r_i;
                wr_data = r_hold;
            end
            S_SWC: begin
                wr_en = 1'b1;
                wr_addr = r_m;
                wr_data = r_tmp;
            end
            S_DONE: begin
                wr_en = enq_ok;
                wr_addr = r_cnt[AW-1:0];
                wr_data = r_hold;
            end
            default: ;
        endcase
    end

    assign o_ready = (r_state == S_IDLE) && !r_ov;
    assign o_valid = r_ov;
    assign o_data = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt <= '0;
            r_ov <= 1'b0;
        end else begin
            if (r_ov && i_ready) r_ov <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid && o_ready) begin
                        r_req <= i_data;
                        r_i <= '0;
                        r_hit <= 1'b0;
                        r_out <= '0;
                        r_hold <= '{i_data.job_id, i_data.priority_req,
                                    i_data.job_kind, i_data.cpu_time,
                                    i_data.memory_used};
                        unique case (i_data.operation)
                            OP_ENQ, OP_DEQ, OP_MOD, OP_CHG, OP_PRO:
                                r_state <= (r_cnt == '0) ? S_ACT : S_FRD;
                            OP_SRT: begin
                                if (i_data.sort_key >= SK_ID && i_data.sort_key <= SK_MEM
                                    && r_cnt > CW'(1)) begin
                                    r_state <= S_SWA;
                                end else begin
                                    r_state <= S_DONE;
                                end
                            end
                            default: r_state <= S_DONE;
                        endcase
                    end
                end
                S_FRD: r_state <= S_FCHK;
                S_FCHK: begin
                    if (r_req.operation == OP_DEQ) begin
                        {r_out.out_job_id, r_out.out_priority, r_out.out_job_kind,
                         r_out.out_cpu_time, r_out.out_memory_used} <= r_rd;
                        if (r_cnt == CW'(1)) begin
                            r_cnt <= '0;
                            r_state <= S_DONE;
                        end else begin
                            r_j <= '0;
                            r_i <= AW'(1);
                            r_state <= S_SHRD;
                        end
                    end else if (r_rd.id == r_req.job_id) begin
                        r_hit <= 1'b1;
                        r_tgt <= r_i;
                        r_tmp <= r_rd;
                        r_state <= S_ACT;
                    end else if (i_ext + CW'(1) >= r_cnt) begin
                        r_state <= S_ACT;
                    end else begin
                        r_i <= r_i + AW'(1);
                        r_state <= S_FRD;
                    end
                end
                S_ACT: begin
                    r_state <= pro_shift ? S_SHRD : S_DONE;
                    unique case (r_req.operation)
                        OP_ENQ: begin
                            if (r_hit) begin
                                r_out.status <= ST_DUP;
                                r_out.position <= p5(r_tgt);
                                {r_out.out_job_id, r_out.out_priority, r_out.out_job_kind,
                                 r_out.out_cpu_time, r_out.out_memory_used} <= r_tmp;
                            end else if (r_cnt >= CW'(DEPTH)) begin
                                r_out.status <= ST_FULL;
                            end else begin
                                r_out.position <= cnt_w[4:0];
                                {r_out.out_job_id, r_out.out_priority, r_out.out_job_kind,
                                 r_out.out_cpu_time, r_out.out_memory_used} <= r_hold;
                            end
                        end
                        OP_DEQ: r_out.status <= ST_EMPT;
                        OP_MOD, OP_CHG: begin
                            if (r_hit) begin
                                r_out.position <= p5(r_tgt);
                                {r_out.out_job_id, r_out.out_priority, r_out.out_job_kind,
                                 r_out.out_cpu_time, r_out.out_memory_used} <= upd;
                            end else begin
                                r_out.status <= ST_NONE;
                            end
                        end
                        OP_PRO: begin
                            if (!r_hit) begin
                                r_out.status <= ST_NONE;
                            end else begin
                                r_out.position <= p5(pro_dst);
                                {r_out.out_job_id, r_out.out_priority, r_out.out_job_kind,
                                 r_out.out_cpu_time, r_out.out_memory_used} <= r_tmp;
                                // shift up: slot k <- slot k-1 from the job down to dst+1
                                r_j <= r_tgt;
                                r_i <= r_tgt - AW'(1);
                                r_m <= pro_dst;
                            end
                        end
                        default: ;
                    endcase
                end
                S_SHRD: r_state <= S_SHWR;
                S_SHWR: begin
                    // r_rd (slot r_i) is written to slot r_j this cycle
                    if (r_req.operation == OP_DEQ) begin
                        if (i_ext + CW'(1) >= r_cnt) begin
                            r_cnt <= r_cnt - CW'(1);
                            r_state <= S_DONE;
                        end else begin
                            r_j <= r_i;
                            r_i <= r_i + AW'(1);
                            r_state <= S_SHRD;
                        end
                    end else if (r_i == r_m) begin
                        r_state <= S_SWC; // held job goes to its new slot
                    end else begin
                        r_j <= r_i;
                        r_i <= r_i - AW'(1);
                        r_state <= S_SHRD;
                    end
                end
                // selection sort: r_i outer, r_j scan, r_m first minimum
                S_SWA: r_state <= S_SRD;
                S_SRD: begin
                    r_tmp <= r_rd;
                    r_hold <= r_rd;
                    r_mkey <= scan_key;
                    r_m <= r_i;
                    r_j <= r_i + AW'(1);
                    r_state <= S_SCMP;
                end
                S_SCMP: begin
                    if (key_lt) begin
                        r_m <= r_j;
                        r_mkey <= scan_key;
                        r_hold <= r_rd;
                    end
                    if (j_ext + CW'(1) < r_cnt) begin
                        r_j <= r_j + AW'(1);
                    end else if (key_lt || r_m != r_i) begin
                        r_state <= S_SWB;
                    end else if (i_ext + CW'(2) >= r_cnt) begin
                        r_state <= S_DONE;
                    end else begin
                        r_i <= r_i + AW'(1);
                        r_state <= S_SWA;
                    end
                end
                S_SWB: r_state <= S_SWC;
                S_SWC: begin
                    if (r_req.operation != OP_SRT || i_ext + CW'(2) >= r_cnt) begin
                        r_state <= S_DONE;
                    end else begin
                        r_i <= r_i + AW'(1);
                        r_state <= S_SWA;
                    end
                end
                S_DONE: begin
                    if (enq_ok) r_cnt <= r_cnt + CW'(1);
                    r_out.occupancy <= enq_ok ? 5'(cnt_w + 1) : cnt_w[4:0];
                    r_ov <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

// File: tb/job_table_queue_engine_top_test.sv
// Testbench for the job table queue engine: directed and random transactions checked against a queue model.
`timescale 1ns / 100ps
`default_nettype none
module job_table_queue_engine_top_test;
    import jtq_pkg::*;

    localparam int DEPTH = 16;
    localparam logic [2:0] OP_CNT = 3'd6;
    localparam logic [2:0] OP_BAD = 3'd7;
    localparam int CYCLE_LIMIT = 1500000;

    class job_scoreboard;
        t_rec  slots[DEPTH];
        int    count;
        t_out  pending[$];
        int    errors;

        function new();
            count = 0;
            errors = 0;
        endfunction

        function int find_id(logic [15:0] id);
            for (int i = 0; i < count; i++) begin
                if (slots[i].id == id) return i;
            end
            return -1;
        endfunction

        function logic [31:0] key_val(int i, logic [2:0] k);
            case (k)
                SK_ID:   return 32'(slots[i].id);
                SK_PRI:  return 32'(slots[i].pri);
                SK_KND:  return 32'(slots[i].kind);
                SK_CPU:  return slots[i].cpu;
                default: return slots[i].mem;
            endcase
        endfunction

        function void show(ref t_out r, input int i);
            r.position = i[4:0];
            r.out_job_id = slots[i].id;
            r.out_priority = slots[i].pri;
            r.out_job_kind = slots[i].kind;
            r.out_cpu_time = slots[i].cpu;
            r.out_memory_used = slots[i].mem;
        endfunction

        function void note_input(t_in t);
            t_out r;
            t_rec tmp;
            int p, j, m;
            r = '0;
            r.status = ST_OK;
            case (t.operation)
                OP_ENQ: begin
                    p = find_id(t.job_id);
                    if (p >= 0) begin
                        r.status = ST_DUP;
                        show(r, p);
                    end else if (count >= DEPTH) begin
                        r.status = ST_FULL;
                    end else begin
                        slots[count] = '{t.job_id, t.priority_req, t.job_kind,
                                         t.cpu_time, t.memory_used};
                        show(r, count);
                        count++;
                    end
                end
                OP_DEQ: begin
                    if (count == 0) begin
                        r.status = ST_EMPT;
                    end else begin
                        show(r, 0);
                        r.position = '0;
                        for (int i = 0; i + 1 < count; i++) slots[i] = slots[i + 1];
                        count--;
                    end
                end
                OP_MOD, OP_CHG: begin
                    p = find_id(t.job_id);
                    if (p < 0) begin
                        r.status = ST_NONE;
                    end else begin
                        if (t.operation == OP_MOD) begin
                            slots[p].pri = t.priority_req;
                            slots[p].kind = t.job_kind;
                            slots[p].cpu = t.cpu_time;
                            slots[p].mem = t.memory_used;
                        end else begin
                            case (t.field_select)
                                FS_PRI: slots[p].pri = (t.field_value > 15) ? 4'hF
                                                                            : t.field_value[3:0];
                                FS_KND: slots[p].kind = (t.field_value > 15) ? 4'hF
                                                                             : t.field_value[3:0];
                                FS_CPU: slots[p].cpu = t.field_value;
                                FS_MEM: slots[p].mem = t.field_value;
                                default: ;
                            endcase
                        end
                        show(r, p);
                    end
                end
                OP_PRO: begin
                    p = find_id(t.job_id);
                    if (p < 0) begin
                        r.status = ST_NONE;
                    end else begin
                        j = (t.positions >= p) ? 0 : p - t.positions;
                        tmp = slots[p];
                        for (int i = p; i > j; i--) slots[i] = slots[i - 1];
                        slots[j] = tmp;
                        show(r, j);
                    end
                end
                OP_SRT: begin
                    if (t.sort_key >= SK_ID && t.sort_key <= SK_MEM) begin
                        for (int i = 0; i < count; i++) begin
                            m = i;
                            for (int k = i + 1; k < count; k++)
                                if (key_val(k, t.sort_key) < key_val(m, t.sort_key)) m = k;
                            if (m != i) begin
                                tmp = slots[i];
                                slots[i] = slots[m];
                                slots[m] = tmp;
                            end
                        end
                    end
                end
                default: ;
            endcase
            r.occupancy = count[4:0];
            pending.push_back(r);
        endfunction

        function void check_result(t_out got);
            t_out exp_r;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result %h", $realtime, got);
                errors++;
                return;
            end
            exp_r = pending.pop_front();
            if (got !== exp_r) begin
                $display("%0t: mismatch expected %h actual %h", $realtime, exp_r, got);
                if (got.status !== exp_r.status)
                    $display("  status expected %0d actual %0d", exp_r.status, got.status);
                if (got.position !== exp_r.position)
                    $display("  position expected %0d actual %0d", exp_r.position, got.position);
                if (got.occupancy !== exp_r.occupancy)
                    $display("  occupancy expected %0d actual %0d", exp_r.occupancy, got.occupancy);
                errors++;
            end
        endfunction
    endclass

    logic i_clk, i_rst_n, i_valid, i_ready, o_ready, o_valid;
    t_in  i_data;
    t_out o_data;
    job_scoreboard sb;
    int send_idle, recv_stall, hold_off, cycles;
    logic [15:0] used_ids[$];

    job_table_queue_engine_top #(.DEPTH(DEPTH)) i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_ready(o_ready),
        .i_data(i_data), .o_valid(o_valid), .i_ready(i_ready), .o_data(o_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        sb = new();
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_ready = 1'b0;
        i_data = '0;
        send_idle = 0;
        recv_stall = 0;
        hold_off = 0;
    end

    // receiver: random stall plus optional long hold-off
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && i_ready) sb.check_result(o_data);
            if (hold_off > 0) begin
                hold_off <= hold_off - 1;
                i_ready <= 1'b0;
            end else begin
                i_ready <= ($urandom_range(99) >= recv_stall);
            end
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("job_table_queue_engine_top_test NOT OK");
            $finish;
        end
    end
    initial cycles = 0;

    function automatic logic [15:0] pick_id();
        if (used_ids.size() > 0 && $urandom_range(3) != 0)
            return used_ids[$urandom_range(used_ids.size() - 1)];
        return {12'h0, 4'($urandom)} ^ (($urandom_range(7) == 0) ? 16'($urandom) : 16'h0);
    endfunction

    function automatic logic [31:0] wide_val();
        case ($urandom_range(3))
            0: return $urandom_range(20);
            1: return 32'hFFFF_FFFF - $urandom_range(3);
            default: return $urandom;
        endcase
    endfunction

    function automatic t_in rand_item();
        t_in t;
        int r;
        t = '0;
        t.job_id = pick_id();
        t.priority_req = 4'($urandom);
        t.job_kind = 4'($urandom);
        t.cpu_time = wide_val();
        t.memory_used = wide_val();
        t.field_select = 3'($urandom);
        t.field_value = wide_val();
        t.positions = ($urandom_range(1) == 0) ? 8'($urandom_range(4)) : 8'($urandom);
        t.sort_key = 3'($urandom);
        r = $urandom_range(99);
        if (r < 30)      t.operation = OP_ENQ;
        else if (r < 45) t.operation = OP_DEQ;
        else if (r < 58) t.operation = OP_MOD;
        else if (r < 75) t.operation = OP_CHG;
        else if (r < 88) t.operation = OP_PRO;
        else if (r < 93) t.operation = OP_SRT;
        else if (r < 97) t.operation = OP_CNT;
        else             t.operation = OP_BAD;
        if (t.operation == OP_ENQ) used_ids.push_back(t.job_id);
        return t;
    endfunction

    // valid stays high from one transaction to the next unless the sender idles or waits for the drain
    task automatic send_item(t_in t);
        while ($urandom_range(99) < send_idle) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data <= t;
        do @(posedge i_clk); while (!o_ready);
        sb.note_input(t);
    endtask

    task automatic wait_drain();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (sb.pending.size() != 0);
    endtask

    function automatic t_in mk(logic [2:0] op, logic [15:0] id);
        t_in t;
        t = '0;
        t.operation = op;
        t.job_id = id;
        return t;
    endfunction

    initial begin
        t_in t;
        #0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty dequeue, not found, fill to full, duplicate, change, promote, sort, count, bad op
        send_item(mk(OP_DEQ, 16'h0000));
        send_item(mk(OP_MOD, 16'h1234));
        send_item(mk(OP_PRO, 16'h1234));
        for (int i = 0; i < DEPTH; i++) begin
            t = mk(OP_ENQ, (i == 0) ? 16'hFFFF : 16'(DEPTH - i));
            t.priority_req = 4'(i);
            t.job_kind = ~4'(i);
            t.cpu_time = (i == 1) ? 32'hFFFF_FFFF : 32'(i * 77);
            t.memory_used = 32'hFFFF_FFFF - 32'(i);
            send_item(t);
            used_ids.push_back(t.job_id);
        end
        send_item(mk(OP_ENQ, 16'h0000));
        send_item(mk(OP_ENQ, 16'hFFFF));
        t = mk(OP_CHG, 16'd3); t.field_select = FS_PRI; t.field_value = 32'hFFFF_FFFF;
        send_item(t);
        t.field_select = 3'd7; send_item(t);
        t = mk(OP_PRO, 16'd1); t.positions = 8'hFF; send_item(t);
        t = mk(OP_SRT, 16'h0000); t.sort_key = 3'd0; send_item(t);
        t.sort_key = SK_MEM; send_item(t);
        send_item(mk(OP_CNT, 16'h0000));
        send_item(mk(OP_BAD, 16'h0000));
        wait_drain();

        for (int ph = 0; ph < 5; ph++) begin
            case (ph)
                0: begin send_idle = 0;  recv_stall = 0;  end
                1: begin send_idle = 50; recv_stall = 0;  end
                2: begin send_idle = 0;  recv_stall = 50; end
                3: begin send_idle = 25; recv_stall = 25; end
                default: begin send_idle = 0; recv_stall = 10; end
            endcase
            if (ph == 4) hold_off <= 300;
            if (ph == 2) begin
                for (int i = 0; i < DEPTH + 2; i++) send_item(mk(OP_DEQ, 16'h0000));
                used_ids.delete();
            end
            for (int i = 0; i < 150; i++) begin
                send_item(rand_item());
                if (used_ids.size() > 40) used_ids.delete(0);
            end
            wait_drain();
        end
        wait_drain();
        repeat (600) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("job_table_queue_engine_top_test OK");
        else
            $display("job_table_queue_engine_top_test NOT OK");
        $finish;
    end
endmodule
`default_nettype wire

// File: files.f
hw/rtl/jtq_pkg.sv
hw/rtl/job_table_queue_engine_top.sv
tb/job_table_queue_engine_top_test.sv
